// ----- hdl/hcte_pkg.sv -----
// ----------------------------------------------------------------------------
// hcte_pkg
// Shared types, field widths, command codes and datapath operation codes of
// the chained hash table engine.
// ----------------------------------------------------------------------------
package hcte_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int ECNT_W = 10;
    localparam int BCNT_W = 11;
    localparam int OP_W   = 5;

    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [KEY_W-1:0]         key_t;
    typedef logic signed [VAL_W-1:0]  value_t;
    typedef logic [ECNT_W-1:0]        ecnt_t;
    typedef logic [BCNT_W-1:0]        bcnt_t;
    typedef logic [OP_W-1:0]          op_t;

    // Bucket count after reset, before any configuration write
    localparam bcnt_t RST_BUCKETS = 11'd8;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_GET    = 2'd1;
    localparam cmd_t CMD_REMOVE = 2'd2;
    localparam cmd_t CMD_UNUSED = 2'd3;

    // Datapath operations issued by the controller, one per cycle
    localparam op_t OP_NONE       = 5'd0;
    localparam op_t OP_ACCEPT     = 5'd1;
    localparam op_t OP_BUCKET     = 5'd2;
    localparam op_t OP_LOAD_HEAD  = 5'd3;
    localparam op_t OP_STEP       = 5'd4;
    localparam op_t OP_UPDATE     = 5'd5;
    localparam op_t OP_GET        = 5'd6;
    localparam op_t OP_UNLINK     = 5'd7;
    localparam op_t OP_FREE       = 5'd8;
    localparam op_t OP_FULL       = 5'd9;
    localparam op_t OP_TAKE_FREE  = 5'd10;
    localparam op_t OP_POP_FREE   = 5'd11;
    localparam op_t OP_TAKE_FRESH = 5'd12;
    localparam op_t OP_FILL       = 5'd13;
    localparam op_t OP_LINK       = 5'd14;
    localparam op_t OP_GROW_INIT  = 5'd15;
    localparam op_t OP_NEXT_BKT   = 5'd16;
    localparam op_t OP_CAT_HEAD   = 5'd17;
    localparam op_t OP_CAT_END    = 5'd18;
    localparam op_t OP_RETARGET   = 5'd19;
    localparam op_t OP_CLEAR      = 5'd20;
    localparam op_t OP_DIST_START = 5'd21;
    localparam op_t OP_DIST_DIV   = 5'd22;
    localparam op_t OP_DIST_PUT   = 5'd23;
    localparam op_t OP_RESULT     = 5'd24;

    typedef struct packed {
        op_t op;
    } hcte_cmd_t;

    typedef struct packed {
        logic div_done;
        logic e_nil;
        logic key_hit;
        logic head_nil;
        logic link_nil;
        logic free_nil;
        logic full;
        logic grow_need;
        logic bkt_last;
        cmd_t command;
    } hcte_stat_t;

endpackage

// ----- hdl/hcte_if.sv -----
// ----------------------------------------------------------------------------
// hcte_req_if / hcte_rsp_if
// Valid/ready channels carrying requests into and responses out of the
// chained hash table engine.
// ----------------------------------------------------------------------------
interface hcte_req_if;
    import hcte_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    key_t   key;
    value_t value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface hcte_rsp_if;
    import hcte_pkg::*;

    logic   valid;
    logic   ready;
    logic   found;
    value_t read_value;
    logic   status;
    ecnt_t  entry_count;
    bcnt_t  bucket_count;

    modport source (output valid, output found, output read_value, output status,
                    output entry_count, output bucket_count, input ready);
    modport sink   (input valid, input found, input read_value, input status,
                    input entry_count, input bucket_count, output ready);
endinterface

// ----- hdl/hcte_div.sv -----
// ----------------------------------------------------------------------------
// hcte_div
// Bit-serial restoring remainder unit: key modulo bucket count, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module hcte_div #(
    parameter int BW = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hcte_pkg::key_t        dividend,
    input  logic [BW-1:0]         divisor,
    output logic                  done,
    output logic [BW-1:0]         rem
);
    import hcte_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(KEY_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BW-1:0]    rem_reg, rem_next;
    key_t             dvd_reg, dvd_next;
    logic [BW:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        trial     = {rem_reg, dvd_reg[KEY_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            // subtract when the partial remainder reaches the divisor
            if (trial >= {1'b0, divisor})
                rem_next = BW'(trial - {1'b0, divisor});
            else
                rem_next = trial[BW-1:0];
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/hcte_dp.sv -----
// ----------------------------------------------------------------------------
// hcte_dp
// Datapath: bucket head memory, entry pool memories, free list, counters,
// remainder unit and the response register.
// ----------------------------------------------------------------------------
module hcte_dp #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_ENTRIES = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  hcte_pkg::bcnt_t       cfg_wr_data,
    input  hcte_pkg::cmd_t        in_command,
    input  hcte_pkg::key_t        in_key,
    input  hcte_pkg::value_t      in_value,
    input  hcte_pkg::hcte_cmd_t   cmd,
    output hcte_pkg::hcte_stat_t  stat,
    output logic                  found,
    output hcte_pkg::value_t      read_value,
    output logic                  status,
    output hcte_pkg::ecnt_t       entry_count,
    output hcte_pkg::bcnt_t       bucket_count
);
    import hcte_pkg::*;

    localparam int BW  = $clog2(MAX_BUCKETS + 1);
    localparam int BIW = $clog2(MAX_BUCKETS);
    localparam int EIW = $clog2(MAX_ENTRIES + 1);
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = ((EIW > BW) ? EIW : BW) + 1;
    localparam logic [EIW-1:0] NIL  = EIW'(MAX_ENTRIES);
    localparam logic [BW-1:0]  MAXB = BW'(MAX_BUCKETS);

    function automatic logic [BW-1:0] clamp_cnt(input bcnt_t n);
        logic [BW-1:0] r;
        if (n == '0)
            r = BW'(1);
        else if (32'(n) > 32'(MAX_BUCKETS))
            r = MAXB;
        else
            r = BW'(n);
        return r;
    endfunction

    // memories
    logic [EIW-1:0] head_mem [MAX_BUCKETS];
    key_t           key_mem  [MAX_ENTRIES];
    value_t         val_mem  [MAX_ENTRIES];
    logic [EIW-1:0] link_mem [MAX_ENTRIES];

    logic [EIW-1:0] head_rd_reg;
    key_t           key_rd_reg;
    value_t         val_rd_reg;
    logic [EIW-1:0] link_rd_reg;

    // control registers
    logic [BW-1:0]  cur_reg, cur_next;
    logic [EIW-1:0] stored_reg, stored_next;
    logic [EIW-1:0] free_reg, free_next;
    logic [EIW-1:0] fresh_reg, fresh_next;
    logic [BIW-1:0] bkt_reg, bkt_next;

    // payload registers
    cmd_t           cmd_reg, cmd_next;
    key_t           key_reg, key_next;
    value_t         val_reg, val_next;
    logic [EIW-1:0] e_reg, e_next;
    logic [EIW-1:0] prev_reg, prev_next;
    logic [EIW-1:0] nx_reg, nx_next;
    logic [EIW-1:0] lh_reg, lh_next;
    logic [EIW-1:0] lt_reg, lt_next;
    logic           res_found_reg, res_found_next;
    logic           res_status_reg, res_status_next;
    value_t         res_rd_reg, res_rd_next;
    logic           out_found_reg, out_found_next;
    value_t         out_rd_reg, out_rd_next;
    logic           out_status_reg, out_status_next;
    ecnt_t          out_ecnt_reg, out_ecnt_next;
    bcnt_t          out_bcnt_reg, out_bcnt_next;

    // write controls
    logic           head_we;
    logic [EIW-1:0] head_wdata;
    logic           key_we;
    logic           val_we;
    logic           link_we;
    logic [EIW-1:0] link_waddr;
    logic [EIW-1:0] link_wdata;

    logic           div_start;
    key_t           div_dividend;
    logic           div_done;
    logic [BW-1:0]  div_rem;

    logic [BW:0]    dbl;
    logic [BW-1:0]  target;
    logic [BW-1:0]  cur_m1;
    logic [EAW-1:0] e_addr;

    assign e_addr = e_reg[EAW-1:0];
    assign dbl    = {cur_reg, 1'b0};
    assign target = (dbl > (BW+1)'(MAX_BUCKETS)) ? MAXB : dbl[BW-1:0];
    assign cur_m1 = cur_reg - 1'b1;

    hcte_div #(.BW(BW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cur_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        cur_next        = cur_reg;
        stored_next     = stored_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        bkt_next        = bkt_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        e_next          = e_reg;
        prev_next       = prev_reg;
        nx_next         = nx_reg;
        lh_next         = lh_reg;
        lt_next         = lt_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        out_found_next  = out_found_reg;
        out_rd_next     = out_rd_reg;
        out_status_next = out_status_reg;
        out_ecnt_next   = out_ecnt_reg;
        out_bcnt_next   = out_bcnt_reg;
        head_we         = 1'b0;
        head_wdata      = NIL;
        key_we          = 1'b0;
        val_we          = 1'b0;
        link_we         = 1'b0;
        link_waddr      = e_reg;
        link_wdata      = NIL;
        div_start       = 1'b0;
        div_dividend    = key_reg;

        case (cmd.op)
            OP_ACCEPT:
            begin
                cmd_next        = in_command;
                key_next        = in_key;
                val_next        = in_value;
                res_found_next  = 1'b0;
                res_status_next = 1'b0;
                res_rd_next     = '1;
                div_start       = 1'b1;
                div_dividend    = in_key;
            end
            OP_BUCKET:
                bkt_next = div_rem[BIW-1:0];
            OP_LOAD_HEAD:
            begin
                e_next    = head_rd_reg;
                prev_next = NIL;
            end
            OP_STEP:
            begin
                prev_next = e_reg;
                e_next    = link_rd_reg;
            end
            OP_UPDATE:
            begin
                val_we         = 1'b1;
                res_found_next = 1'b1;
            end
            OP_GET:
            begin
                res_found_next = 1'b1;
                res_rd_next    = val_rd_reg;
            end
            OP_UNLINK:
            begin
                res_found_next = 1'b1;
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rd_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg;
                    link_wdata = link_rd_reg;
                end
            end
            OP_FREE:
            begin
                link_we     = 1'b1;
                link_wdata  = free_reg;
                free_next   = e_reg;
                stored_next = stored_reg - 1'b1;
            end
            OP_FULL:
                res_status_next = 1'b1;
            OP_TAKE_FREE:
                e_next = free_reg;
            OP_POP_FREE:
                free_next = link_rd_reg;
            OP_TAKE_FRESH:
            begin
                e_next     = fresh_reg;
                fresh_next = fresh_reg + 1'b1;
            end
            OP_FILL:
            begin
                key_we      = 1'b1;
                val_we      = 1'b1;
                link_we     = 1'b1;
                stored_next = stored_reg + 1'b1;
            end
            OP_LINK:
            begin
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = e_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg;
                    link_wdata = e_reg;
                end
            end
            OP_GROW_INIT:
            begin
                bkt_next = '0;
                lh_next  = NIL;
                lt_next  = NIL;
            end
            OP_NEXT_BKT:
                bkt_next = bkt_reg + 1'b1;
            OP_CAT_HEAD:
            begin
                // append this chain to the single rehash list
                e_next = head_rd_reg;
                if (lt_reg == NIL)
                    lh_next = head_rd_reg;
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = lt_reg;
                    link_wdata = head_rd_reg;
                end
            end
            OP_CAT_END:
            begin
                lt_next  = e_reg;
                bkt_next = bkt_reg + 1'b1;
            end
            OP_RETARGET:
            begin
                cur_next = target;
                bkt_next = '0;
            end
            OP_CLEAR:
            begin
                head_we  = 1'b1;
                bkt_next = bkt_reg + 1'b1;
            end
            OP_DIST_START:
                e_next = lh_reg;
            OP_DIST_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = key_rd_reg;
                nx_next      = link_rd_reg;
            end
            OP_DIST_PUT:
            begin
                // push the entry on the front of its new bucket
                link_we    = 1'b1;
                link_wdata = head_rd_reg;
                head_we    = 1'b1;
                head_wdata = e_reg;
                e_next     = nx_reg;
            end
            OP_RESULT:
            begin
                out_found_next  = res_found_reg;
                out_rd_next     = res_rd_reg;
                out_status_next = res_status_reg;
                out_ecnt_next   = ECNT_W'(stored_reg);
                out_bcnt_next   = BCNT_W'(cur_reg);
            end
            default:
            begin
            end
        endcase

        // rebuild an empty table
        if (cfg_wr_en)
        begin
            cur_next    = clamp_cnt(cfg_wr_data);
            stored_next = '0;
            free_next   = NIL;
            fresh_next  = '0;
            bkt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= clamp_cnt(RST_BUCKETS);
            stored_reg <= '0;
            free_reg   <= NIL;
            fresh_reg  <= '0;
            bkt_reg    <= '0;
        end
        else
        begin
            cur_reg    <= cur_next;
            stored_reg <= stored_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            bkt_reg    <= bkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        e_reg          <= e_next;
        prev_reg       <= prev_next;
        nx_reg         <= nx_next;
        lh_reg         <= lh_next;
        lt_reg         <= lt_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        out_found_reg  <= out_found_next;
        out_rd_reg     <= out_rd_next;
        out_status_reg <= out_status_next;
        out_ecnt_reg   <= out_ecnt_next;
        out_bcnt_reg   <= out_bcnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[bkt_reg] <= head_wdata;
        head_rd_reg <= head_mem[bkt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[e_addr] <= key_reg;
        key_rd_reg <= key_mem[e_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[e_addr] <= val_reg;
        val_rd_reg <= val_mem[e_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr[EAW-1:0]] <= link_wdata;
        link_rd_reg <= link_mem[e_addr];
    end

    always_comb
    begin
        stat.div_done  = div_done;
        stat.e_nil     = (e_reg == NIL);
        stat.key_hit   = (key_rd_reg == key_reg);
        stat.head_nil  = (head_rd_reg == NIL);
        stat.link_nil  = (link_rd_reg == NIL);
        stat.free_nil  = (free_reg == NIL);
        stat.full      = (stored_reg == NIL);
        stat.grow_need = (CW'({stored_reg, 1'b0}) >= CW'(cur_reg)) && (cur_reg != MAXB);
        stat.bkt_last  = (bkt_reg == cur_m1[BIW-1:0]);
        stat.command   = cmd_reg;
    end

    assign found        = out_found_reg;
    assign read_value   = out_rd_reg;
    assign status       = out_status_reg;
    assign entry_count  = out_ecnt_reg;
    assign bucket_count = out_bcnt_reg;

endmodule

// ----- hdl/hcte_ctrl.sv -----
// ----------------------------------------------------------------------------
// hcte_ctrl
// Controller: sequences lookups, inserts, removes, rehash and clearing
// passes, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module hcte_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  hcte_pkg::hcte_stat_t  stat,
    output hcte_pkg::hcte_cmd_t   cmd
);
    import hcte_pkg::*;

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_DIV    = 5'd2;
    localparam logic [4:0] ST_HW     = 5'd3;
    localparam logic [4:0] ST_HL     = 5'd4;
    localparam logic [4:0] ST_EW     = 5'd5;
    localparam logic [4:0] ST_CMP    = 5'd6;
    localparam logic [4:0] ST_REM2   = 5'd7;
    localparam logic [4:0] ST_ALW    = 5'd8;
    localparam logic [4:0] ST_ALF    = 5'd9;
    localparam logic [4:0] ST_ALLOC  = 5'd10;
    localparam logic [4:0] ST_LINK   = 5'd11;
    localparam logic [4:0] ST_GCHK   = 5'd12;
    localparam logic [4:0] ST_RA_W   = 5'd13;
    localparam logic [4:0] ST_RA_H   = 5'd14;
    localparam logic [4:0] ST_RA_EW  = 5'd15;
    localparam logic [4:0] ST_RA_E   = 5'd16;
    localparam logic [4:0] ST_GCLR   = 5'd17;
    localparam logic [4:0] ST_RC_S   = 5'd18;
    localparam logic [4:0] ST_RC_EW  = 5'd19;
    localparam logic [4:0] ST_RC_E   = 5'd20;
    localparam logic [4:0] ST_RC_DIV = 5'd21;
    localparam logic [4:0] ST_RC_HW  = 5'd22;
    localparam logic [4:0] ST_RC_H   = 5'd23;
    localparam logic [4:0] ST_RESP   = 5'd24;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.bkt_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_BUCKET;
                    state_next = ST_HW;
                end
            end
            ST_HW:
                state_next = ST_HL;
            ST_HL:
            begin
                cmd.op     = OP_LOAD_HEAD;
                state_next = ST_EW;
            end
            ST_EW:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (stat.e_nil)
                begin
                    state_next = ST_RESP;
                    if (stat.command == CMD_INSERT)
                    begin
                        if (stat.full)
                            cmd.op = OP_FULL;
                        else if (!stat.free_nil)
                        begin
                            cmd.op     = OP_TAKE_FREE;
                            state_next = ST_ALW;
                        end
                        else
                        begin
                            cmd.op     = OP_TAKE_FRESH;
                            state_next = ST_ALLOC;
                        end
                    end
                end
                else if (stat.key_hit)
                begin
                    state_next = ST_RESP;
                    case (stat.command)
                        CMD_INSERT: cmd.op = OP_UPDATE;
                        CMD_GET:    cmd.op = OP_GET;
                        CMD_REMOVE:
                        begin
                            cmd.op     = OP_UNLINK;
                            state_next = ST_REM2;
                        end
                        default:    cmd.op = OP_NONE;
                    endcase
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = ST_EW;
                end
            end
            ST_REM2:
            begin
                cmd.op     = OP_FREE;
                state_next = ST_RESP;
            end
            ST_ALW:
                state_next = ST_ALF;
            ST_ALF:
            begin
                cmd.op     = OP_POP_FREE;
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                cmd.op     = OP_FILL;
                state_next = ST_LINK;
            end
            ST_LINK:
            begin
                cmd.op     = OP_LINK;
                state_next = ST_GCHK;
            end
            ST_GCHK:
            begin
                if (stat.grow_need)
                begin
                    cmd.op     = OP_GROW_INIT;
                    state_next = ST_RA_W;
                end
                else
                    state_next = ST_RESP;
            end
            ST_RA_W:
                state_next = ST_RA_H;
            ST_RA_H:
            begin
                if (!stat.head_nil)
                begin
                    cmd.op     = OP_CAT_HEAD;
                    state_next = ST_RA_EW;
                end
                else if (stat.bkt_last)
                begin
                    cmd.op     = OP_RETARGET;
                    state_next = ST_GCLR;
                end
                else
                begin
                    cmd.op     = OP_NEXT_BKT;
                    state_next = ST_RA_W;
                end
            end
            ST_RA_EW:
                state_next = ST_RA_E;
            ST_RA_E:
            begin
                if (!stat.link_nil)
                begin
                    cmd.op     = OP_STEP;
                    state_next = ST_RA_EW;
                end
                else if (stat.bkt_last)
                begin
                    cmd.op     = OP_RETARGET;
                    state_next = ST_GCLR;
                end
                else
                begin
                    cmd.op     = OP_CAT_END;
                    state_next = ST_RA_W;
                end
            end
            ST_GCLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.bkt_last)
                    state_next = ST_RC_S;
            end
            ST_RC_S:
            begin
                cmd.op     = OP_DIST_START;
                state_next = ST_RC_EW;
            end
            ST_RC_EW:
                state_next = ST_RC_E;
            ST_RC_E:
            begin
                if (stat.e_nil)
                    state_next = ST_RESP;
                else
                begin
                    cmd.op     = OP_DIST_DIV;
                    state_next = ST_RC_DIV;
                end
            end
            ST_RC_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_BUCKET;
                    state_next = ST_RC_HW;
                end
            end
            ST_RC_HW:
                state_next = ST_RC_H;
            ST_RC_H:
            begin
                cmd.op     = OP_DIST_PUT;
                state_next = ST_RC_EW;
            end
            ST_RESP:
            begin
                // hold until the response register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_CLR;
        endcase

        if (cfg_wr_en)
            state_next = ST_CLR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/chained_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Key-value store with separately chained buckets over a fixed entry pool.
// ----------------------------------------------------------------------------
// One request at a time. The bucket index comes from a bit-serial remainder
// unit, so a get, remove or update first computes that index and then walks
// the chain of that bucket entry by entry up to the key. An insert that
// triggers growth adds a rehash: it gathers the chains of the old buckets
// into one list, clears the heads of the new buckets and redistributes
// every entry (one remainder each). After reset and after every bucket
// count configuration write the head memory is cleared at one bucket per
// cycle and no request is taken meanwhile. The response sits in its own
// register, so a finished response may wait while the next request is
// being accepted.
module chained_hash_table_engine #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_ENTRIES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  hcte_pkg::bcnt_t   cfg_wr_data,
    hcte_req_if.sink          request,
    hcte_rsp_if.source        response
);
    import hcte_pkg::*;

    hcte_cmd_t  cmd;
    hcte_stat_t stat;

    hcte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hcte_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_command   (request.command),
        .in_key       (request.key),
        .in_value     (request.value),
        .cmd          (cmd),
        .stat         (stat),
        .found        (response.found),
        .read_value   (response.read_value),
        .status       (response.status),
        .entry_count  (response.entry_count),
        .bucket_count (response.bucket_count)
    );

`ifndef SYNTHESIS
    // one request in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request accepted while another is in progress");

    a_refuse_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> !(response.status && response.found))
        else $error("refused insert reported as found");

    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (32'(response.entry_count) <= MAX_ENTRIES)
                           && (response.bucket_count != '0))
        else $error("response counts out of range");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives insert, get, remove and unused-command requests into the chained hash
// table engine under random idling and checks every response against a behavioral table.
// ----------------------------------------------------------------------------
module testbench;
    import hcte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS = 1024;
    localparam int NUM_ENTRIES = 512;
    localparam int NIL         = NUM_ENTRIES;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic   found;
        value_t read_value;
        logic   status;
        ecnt_t  entry_count;
        bcnt_t  bucket_count;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    bcnt_t cfg_wr_data;

    hcte_req_if request();
    hcte_rsp_if response();

    chained_hash_table_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request.sink),
        .response    (response.source)
    );

    // Behavioral copy of the table
    int unsigned heads [NUM_BUCKETS];
    int unsigned keys  [NUM_ENTRIES];
    int unsigned vals  [NUM_ENTRIES];
    int unsigned links [NUM_ENTRIES];
    int unsigned stored;
    int unsigned buckets;
    int unsigned free_top;
    int unsigned init_buckets;

    outcome_t pending_outcomes[$];
    key_t     live_keys[$];
    int       errors;
    int       cycles;
    bit       hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void table_clear();
        for (int i = 0; i < NUM_BUCKETS; i++)
            heads[i] = NIL;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            keys[i]  = 0;
            vals[i]  = 0;
            links[i] = i + 1;
        end
        free_top = 0;
        stored   = 0;
        buckets  = (init_buckets < 1) ? 1 :
                   (init_buckets > NUM_BUCKETS) ? NUM_BUCKETS : init_buckets;
        live_keys.delete();
    endfunction

    function automatic void table_grow();
        int unsigned target;
        int unsigned nh [NUM_BUCKETS];
        int unsigned nt [NUM_BUCKETS];
        int unsigned e;
        int unsigned nx;
        int unsigned nb;
        target = buckets * 2;
        if (target > NUM_BUCKETS)
            target = NUM_BUCKETS;
        if (target == buckets)
            return;
        for (int b = 0; b < target; b++)
        begin
            nh[b] = NIL;
            nt[b] = NIL;
        end
        for (int b = 0; b < buckets; b++)
        begin
            e = heads[b];
            while (e < NIL)
            begin
                nx = links[e];
                nb = keys[e] % target;
                links[e] = NIL;
                if (nt[nb] == NIL)
                    nh[nb] = e;
                else
                    links[nt[nb]] = e;
                nt[nb] = e;
                e = nx;
            end
        end
        for (int b = 0; b < NUM_BUCKETS; b++)
            heads[b] = (b < target) ? nh[b] : NIL;
        buckets = target;
    endfunction

    function automatic outcome_t table_apply(cmd_t cmd, key_t key, value_t value);
        outcome_t res;
        int unsigned b;
        int unsigned e;
        int unsigned prev;
        int unsigned n;
        res.found      = 1'b0;
        res.read_value = -1;
        res.status     = 1'b0;
        b    = key % buckets;
        e    = heads[b];
        prev = NIL;
        while (e < NIL && keys[e] != key)
        begin
            prev = e;
            e    = links[e];
        end
        if (cmd == CMD_INSERT)
        begin
            if (e < NIL)
            begin
                vals[e]   = value;
                res.found = 1'b1;
            end
            else if (free_top >= NIL)
                res.status = 1'b1;
            else
            begin
                n        = free_top;
                free_top = links[n];
                keys[n]  = key;
                vals[n]  = value;
                links[n] = NIL;
                if (prev == NIL)
                    heads[b] = n;
                else
                    links[prev] = n;
                stored++;
                live_keys.push_back(key);
                if (2 * stored >= buckets)
                    table_grow();
            end
        end
        else if (cmd == CMD_GET)
        begin
            if (e < NIL)
            begin
                res.found      = 1'b1;
                res.read_value = vals[e];
            end
        end
        else if (cmd == CMD_REMOVE)
        begin
            if (e < NIL)
            begin
                if (prev == NIL)
                    heads[b] = links[e];
                else
                    links[prev] = links[e];
                links[e] = free_top;
                free_top = e;
                if (stored > 0)
                    stored--;
                res.found = 1'b1;
                foreach (live_keys[i])
                    if (live_keys[i] == key)
                    begin
                        live_keys.delete(i);
                        break;
                    end
            end
        end
        res.entry_count  = stored[ECNT_W-1:0];
        res.bucket_count = buckets[BCNT_W-1:0];
        return res;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Valid stays up after the accepting edge until the next item or idle
    // gap replaces it; ready stays low after a transaction until the engine is idle.
    task automatic send_op(cmd_t cmd, key_t key, value_t value);
        outcome_t res;
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid   <= 1'b1;
        request.command <= cmd;
        request.key     <= key;
        request.value   <= value;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        res = table_apply(cmd, key, value);
        pending_outcomes.push_back(res);
    endtask

    // Response side: random stalls plus a long hold-off on request
    initial
    begin
        int stall;
        response.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                response.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = gap_length();
                if (stall > 0)
                begin
                    response.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            response.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && response.valid && response.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (response.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, response.found);
                    errors++;
                end
                if (response.read_value !== want.read_value)
                begin
                    $error("read_value exp %0d got %0d", want.read_value,
                           response.read_value);
                    errors++;
                end
                if (response.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, response.status);
                    errors++;
                end
                if (response.entry_count !== want.entry_count)
                begin
                    $error("entry_count exp %0d got %0d", want.entry_count,
                           response.entry_count);
                    errors++;
                end
                if (response.bucket_count !== want.bucket_count)
                begin
                    $error("bucket_count exp %0d got %0d", want.bucket_count,
                           response.bucket_count);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        request.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_buckets(bcnt_t n);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        init_buckets = n;
        table_clear();
    endtask

    function automatic key_t pick_key(int unsigned spread);
        if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if ($urandom_range(0, 9) == 0)
            return key_t'($urandom);
        return key_t'($urandom_range(0, spread));
    endfunction

    task automatic test_directed();
        send_op(CMD_GET, 31'd5, 32'sd0);
        send_op(CMD_INSERT, 31'd0, 32'h8000_0000);
        send_op(CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(CMD_INSERT, 31'd8, -32'sd1);
        send_op(CMD_GET, 31'd0, 32'sd0);
        send_op(CMD_GET, 31'h7FFF_FFFF, 32'sd0);
        send_op(CMD_INSERT, 31'd0, 32'sd77);
        send_op(CMD_GET, 31'd0, 32'sd0);
        send_op(CMD_REMOVE, 31'd8, 32'sd0);
        send_op(CMD_REMOVE, 31'd8, 32'sd0);
        send_op(CMD_GET, 31'd8, 32'sd0);
        send_op(CMD_UNUSED, 31'd0, 32'sd5);
        send_op(CMD_INSERT, 31'd16, 32'sd3);
        send_op(CMD_INSERT, 31'd24, 32'sd4);
        send_op(CMD_REMOVE, 31'd16, 32'sd0);
        send_op(CMD_GET, 31'd24, 32'sd0);
    endtask

    task automatic test_register_extremes();
        write_buckets(bcnt_t'(0));
        send_op(CMD_INSERT, 31'd3, 32'sd1);
        send_op(CMD_INSERT, 31'd4, 32'sd2);
        send_op(CMD_GET, 31'd3, 32'sd0);
        write_buckets(bcnt_t'(2047));
        send_op(CMD_INSERT, 31'd1, 32'sd9);
        send_op(CMD_GET, 31'd1, 32'sd0);
        write_buckets(bcnt_t'(1024));
        send_op(CMD_INSERT, 31'd1025, 32'sd8);
        send_op(CMD_GET, 31'd1, 32'sd0);
        write_buckets(bcnt_t'(1));
        send_op(CMD_INSERT, 31'd7, 32'sd7);
    endtask

    task automatic test_pool_full();
        write_buckets(bcnt_t'(1));
        for (int i = 0; i < NUM_ENTRIES + 6; i++)
            send_op(CMD_INSERT, key_t'(i * 3), value_t'($urandom));
        send_op(CMD_INSERT, 31'd6, 32'sd11);
        send_op(CMD_REMOVE, 31'd9, 32'sd0);
        send_op(CMD_INSERT, 31'd1, 32'sd12);
        send_op(CMD_GET, 31'd1, 32'sd0);
    endtask

    task automatic test_random(int count, int unsigned spread);
        cmd_t cmd;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r   = $urandom_range(0, 99);
            cmd = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_GET :
                  (r < 97) ? CMD_REMOVE : CMD_UNUSED;
            send_op(cmd, pick_key(spread), value_t'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(30, 200);
        // Pause until the engine has answered everything
        wait_drained();
        test_random(20, 200);
    endtask

    initial
    begin
        errors          = 0;
        cycles          = 0;
        hold_off        = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        request.valid   = 1'b0;
        request.command = CMD_INSERT;
        request.key     = '0;
        request.value   = '0;
        init_buckets    = RST_BUCKETS;
        table_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_pool_full();
        write_buckets(bcnt_t'(8));
        test_random(150, 60);
        write_buckets(bcnt_t'(3));
        test_backpressure();
        test_random(150, 1000);
        write_buckets(bcnt_t'(512));
        test_random(150, 5000);

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
